FILE: design/mesh_relay_admission_queue_assert.svh
// Assertion macros used by the relay queue back end
`ifndef MESH_RELAY_ADMISSION_QUEUE_ASSERT_SVH
`define MESH_RELAY_ADMISSION_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define MRQ_ASSERT_IMPL(label, clk, rst_n, ant, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("relay queue assertion failed");
`define MRQ_ASSERT_NEXT(label, clk, rst_n, ant, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("relay queue assertion failed");
`else
`define MRQ_ASSERT_IMPL(label, clk, rst_n, ant, cons)
`define MRQ_ASSERT_NEXT(label, clk, rst_n, ant, cons)
`endif
`endif

FILE: design/mrq_pkg.sv
// Types and constants of the mesh relay admission queue
`timescale 1ns / 1ps
package mrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SNR_LIMIT    = 1'b1;

  localparam logic [7:0]  SNR_STEP_MS = 8'd200;
  localparam logic [9:0]  JITTER_MOD  = 10'd1000;
  localparam logic [13:0] DELAY_MIN   = 14'd1000;
  localparam logic [13:0] DELAY_MAX   = 14'd10000;
  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32 bit x
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;

  typedef enum logic [2:0] {
    ST_QUEUED       = 3'd0,
    ST_DUP          = 3'd1,
    ST_DISABLED     = 3'd2,
    ST_SNR_HIGH     = 3'd3,
    ST_TTL_EXPIRED  = 3'd4,
    ST_FULL_EVICTED = 3'd5,
    ST_POPPED       = 3'd6,
    ST_EMPTY        = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    OP_POP   = 2'd0,
    OP_DONE  = 2'd1,
    OP_OFFER = 2'd2
  } op_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        msg_tag;
    logic [15:0]        msg_counter;
    logic signed [15:0] msg_ttl;
    logic signed [7:0]  snr_db;
    logic [15:0]        toa_ms;
    logic [31:0]        random_word;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [13:0] relay_delay_ms;
    logic [15:0] out_tag;
    logic [15:0] out_counter;
  } out_item_t;

  // classified beat handed from the front to the back
  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [15:0] tag;
    logic [15:0] counter;
    logic [13:0] delay;
  } cmd_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] counter;
    logic [13:0] delay;
  } entry_t;

endpackage

FILE: design/mesh_relay_admission_queue.sv
// Top level of the mesh relay admission queue
`timescale 1ns / 1ps
// Admits received radio messages into a circular relay queue of QUEUE_DEPTH
// slots (at most QUEUE_DEPTH-1 entries) and gives exactly one result beat per
// input beat. The front checks a beat and works out the relay delay: pops and
// refused offers go straight to F_PUSH, accepted offers first pass F_DIV,
// F_REM and F_SUM (divide by 1000 via reciprocal multiply, remainder, clamp).
// A two entry command queue feeds the back, which owns the entry RAM; its
// single read port sets the pace: an offer scans the queued counters one by
// one, a pop reads the head slot and a refused offer needs no read.
// The front takes a new beat while the back still works. A finished result
// waits in the output register; while it is held, a next result stalls the back.
module mesh_relay_admission_queue #(
  parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mrq_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mrq_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [mrq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic             f_valid, f_ready, b_valid, b_ready;
  mrq_pkg::cmd_t    f_cmd, b_cmd;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  mrq_pkg::entry_t  ram_wdata, ram_rdata;

  mrq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  mrq_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd)
  );

  mrq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mrq_ram #(
    .WIDTH ($bits(mrq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: design/mrq_ram.sv
// Generic simple dual port RAM with registered read
`timescale 1ns / 1ps
module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mrq_front.sv
// Front end: config registers, admission checks and relay delay arithmetic
`timescale 1ns / 1ps
module mrq_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mrq_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [mrq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output mrq_pkg::cmd_t                       cmd
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_REM  = 5'b00100,
    F_SUM  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_t;

  front_state_t      state_r, state_nxt;
  logic              relay_en_r;
  logic signed [7:0] snr_limit_r;
  mrq_pkg::in_item_t item_r, item_nxt;
  mrq_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [22:0]       q_r, q_nxt;
  logic [9:0]        rem_r, rem_nxt;
  logic [15:0]       term_r, term_nxt;

  logic [60:0] quot_prod;
  logic [32:0] back_prod;
  logic [8:0]  snr_diff;
  logic [17:0] delay_sum;
  logic [13:0] delay_clamped;

  always_comb begin
    quot_prod = 61'(item_r.random_word) * 61'(mrq_pkg::RECIP_1000);
    back_prod = 33'(q_r) * 33'(mrq_pkg::JITTER_MOD);
    // limit >= snr here, so the difference is 0..255
    snr_diff  = {snr_limit_r[7], snr_limit_r} - {item_r.snr_db[7], item_r.snr_db};
    delay_sum = 18'(item_r.toa_ms) + 18'(rem_r) + 18'(term_r);
    if (delay_sum < 18'(mrq_pkg::DELAY_MIN)) begin
      delay_clamped = mrq_pkg::DELAY_MIN;
    end else if (delay_sum > 18'(mrq_pkg::DELAY_MAX)) begin
      delay_clamped = mrq_pkg::DELAY_MAX;
    end else begin
      delay_clamped = delay_sum[13:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    cmd_nxt   = cmd_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    term_nxt  = term_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          item_nxt      = in_data;
          cmd_nxt.tag     = in_data.msg_tag;
          cmd_nxt.counter = in_data.msg_counter;
          cmd_nxt.delay   = '0;
          cmd_nxt.status  = mrq_pkg::ST_QUEUED;
          state_nxt       = F_PUSH;
          // refusal order: disabled, snr high, ttl expired
          priority if (in_data.mode) begin
            cmd_nxt.op = mrq_pkg::OP_POP;
          end else if (!relay_en_r) begin
            cmd_nxt.op     = mrq_pkg::OP_DONE;
            cmd_nxt.status = mrq_pkg::ST_DISABLED;
          end else if (in_data.snr_db > snr_limit_r) begin
            cmd_nxt.op     = mrq_pkg::OP_DONE;
            cmd_nxt.status = mrq_pkg::ST_SNR_HIGH;
          end else if (in_data.msg_ttl <= 16'sd0) begin
            cmd_nxt.op     = mrq_pkg::OP_DONE;
            cmd_nxt.status = mrq_pkg::ST_TTL_EXPIRED;
          end else begin
            cmd_nxt.op = mrq_pkg::OP_OFFER;
            state_nxt  = F_DIV;
          end
        end
      end
      F_DIV: begin
        q_nxt     = quot_prod[60:mrq_pkg::RECIP_SHIFT];
        term_nxt  = 16'(snr_diff[7:0]) * 16'(mrq_pkg::SNR_STEP_MS);
        state_nxt = F_REM;
      end
      F_REM: begin
        rem_nxt   = 10'(item_r.random_word - back_prod[31:0]);
        state_nxt = F_SUM;
      end
      F_SUM: begin
        cmd_nxt.delay = delay_clamped;
        state_nxt     = F_PUSH;
      end
      F_PUSH: begin
        if (cmd_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      relay_en_r  <= 1'b0;
      snr_limit_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == mrq_pkg::REG_RELAY_ENABLE) begin
          relay_en_r <= cfg_wdata[0];
        end else begin
          snr_limit_r <= signed'(cfg_wdata);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    cmd_r  <= cmd_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    term_r <= term_nxt;
  end

  assign in_stall  = (state_r != F_IDLE);
  assign cmd_valid = (state_r == F_PUSH);
  assign cmd       = cmd_r;

endmodule

FILE: design/mrq_cmdq.sv
// Two entry command queue between the front and the back
`timescale 1ns / 1ps
module mrq_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  mrq_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mrq_pkg::cmd_t pop_data
);

  mrq_pkg::cmd_t slot_r [2];
  logic          wr_r, rd_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

FILE: design/mrq_back.sv
// Back end: circular entry queue, duplicate scan and result register
`timescale 1ns / 1ps
`include "mesh_relay_admission_queue_assert.svh"
module mrq_back #(
  parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  mrq_pkg::cmd_t                  cmd,
  output logic                           ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
  output mrq_pkg::entry_t                ram_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
  input  mrq_pkg::entry_t                ram_rdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mrq_pkg::out_item_t             out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_POPRD = 4'b0010,
    B_SCAN  = 4'b0100,
    B_EMIT  = 4'b1000
  } back_state_t;

  back_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt, wp_r, wp_nxt, sp_r, sp_nxt;
  logic               chk_r, chk_nxt;
  logic               out_valid_r, out_valid_nxt;
  mrq_pkg::cmd_t      cur_r, cur_nxt;
  mrq_pkg::out_item_t res_r, res_nxt;
  mrq_pkg::out_item_t out_r, out_nxt;
  logic [PTR_W-1:0]   adv_rp, adv_wp, adv_sp;

  assign adv_rp = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
  assign adv_wp = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
  assign adv_sp = (sp_r == PTR_LAST) ? '0 : sp_r + 1'b1;

  assign cmd_ready = (state_r == B_IDLE);
  assign ram_raddr = (state_r == B_SCAN) ? sp_r : rp_r;
  assign ram_waddr = wp_r;
  assign ram_wdata = '{tag: cur_r.tag, counter: cur_r.counter, delay: cur_r.delay};

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    sp_nxt    = sp_r;
    chk_nxt   = chk_r;
    cur_nxt   = cur_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cur_nxt = cmd;
          res_nxt = '0;
          unique case (cmd.op)
            mrq_pkg::OP_POP: begin
              if (rp_r == wp_r) begin
                res_nxt.status = mrq_pkg::ST_EMPTY;
                state_nxt      = B_EMIT;
              end else begin
                // rp_r is already on the read port
                state_nxt = B_POPRD;
              end
            end
            mrq_pkg::OP_OFFER: begin
              sp_nxt    = rp_r;
              chk_nxt   = 1'b0;
              state_nxt = B_SCAN;
            end
            default: begin
              res_nxt.status = cmd.status;
              state_nxt      = B_EMIT;
            end
          endcase
        end
      end
      B_POPRD: begin
        res_nxt.status         = mrq_pkg::ST_POPPED;
        res_nxt.relay_delay_ms = ram_rdata.delay;
        res_nxt.out_tag        = ram_rdata.tag;
        res_nxt.out_counter    = ram_rdata.counter;
        rp_nxt                 = adv_rp;
        state_nxt              = B_EMIT;
      end
      B_SCAN: begin
        // read of one slot overlaps the compare of the previous one
        if (chk_r && (ram_rdata.counter == cur_r.counter)) begin
          res_nxt.status = mrq_pkg::ST_DUP;
          state_nxt      = B_EMIT;
        end else if (sp_r == wp_r) begin
          if (adv_wp == rp_r) begin
            res_nxt.status = mrq_pkg::ST_FULL_EVICTED;
            rp_nxt         = adv_rp;
          end else begin
            ram_we                 = 1'b1;
            wp_nxt                 = adv_wp;
            res_nxt.status         = mrq_pkg::ST_QUEUED;
            res_nxt.relay_delay_ms = cur_r.delay;
          end
          state_nxt = B_EMIT;
        end else begin
          sp_nxt  = adv_sp;
          chk_nxt = 1'b1;
        end
      end
      B_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (state_r == B_EMIT && (!out_valid_r || !out_stall)) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      sp_r        <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      sp_r        <= sp_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MRQ_ASSERT_IMPL(a_rp_range, clk, rst_n, 1'b1, rp_r <= PTR_LAST)
  `MRQ_ASSERT_IMPL(a_wp_range, clk, rst_n, 1'b1, wp_r <= PTR_LAST)
  `MRQ_ASSERT_NEXT(a_write_moves_wp, clk, rst_n, ram_we, wp_r != $past(wp_r))
  `MRQ_ASSERT_IMPL(a_zero_delay, clk, rst_n, out_valid_r && out_r.status != mrq_pkg::ST_QUEUED && out_r.status != mrq_pkg::ST_POPPED, out_r.relay_delay_ms == '0)

endmodule

FILE: bench/mesh_relay_admission_queue_test.sv
// Self-checking bench for the mesh relay admission queue
`timescale 1ns / 1ps
module mesh_relay_admission_queue_test;

  localparam int DEPTH       = mrq_pkg::QUEUE_DEPTH_DEF;
  localparam int SETTLE      = mrq_pkg::QUEUE_DEPTH_DEF + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int SEGMENTS    = 4;
  localparam int SEG_BEATS   = 85;
  localparam int CTR_POOL    = 24;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                         kind;
    logic [mrq_pkg::CFG_IDX_W-1:0]     idx;
    logic [mrq_pkg::CFG_DATA_W-1:0]    val;
    mrq_pkg::in_item_t                 item;
    int                                reps;
    bit                                typed;
    mrq_pkg::out_item_t                want;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  mrq_pkg::in_item_t               in_data;
  logic                            out_valid;
  logic                            out_stall;
  mrq_pkg::out_item_t              out_data;
  logic                            cfg_we;
  logic [mrq_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [mrq_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  // queue model
  logic [15:0] slot_tag [DEPTH];
  logic [15:0] slot_ctr [DEPTH];
  logic [13:0] slot_delay [DEPTH];
  int          head = 0;
  int          tail = 0;
  logic        relay_on = 1'b0;
  int          snr_cap = 0;

  mrq_pkg::out_item_t awaited_results [$];
  mrq_pkg::out_item_t oldest_result;
  int          mismatches = 0;
  int          send_idle_pct = 18;
  int          recv_idle_pct = 85;
  bit          hold_off_req = 1'b0;
  int          hold_left = 0;
  stim_row_t   plan [$];

  mesh_relay_admission_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mrq_pkg::out_item_t admit_beat(input mrq_pkg::in_item_t it);
    mrq_pkg::out_item_t r;
    int unsigned d;
    int          snr;
    int          ttl;
    int          p;
    bit          seen;
    r = '0;
    snr = $signed(it.snr_db);
    ttl = $signed(it.msg_ttl);
    if (it.mode) begin
      if (head == tail) begin
        r.status = mrq_pkg::ST_EMPTY;
      end else begin
        r.status = mrq_pkg::ST_POPPED;
        r.out_tag = slot_tag[head];
        r.out_counter = slot_ctr[head];
        r.relay_delay_ms = slot_delay[head];
        head = (head + 1) % DEPTH;
      end
    end else if (!relay_on) begin
      r.status = mrq_pkg::ST_DISABLED;
    end else if (snr > snr_cap) begin
      r.status = mrq_pkg::ST_SNR_HIGH;
    end else if (ttl <= 0) begin
      r.status = mrq_pkg::ST_TTL_EXPIRED;
    end else begin
      d = it.toa_ms;
      d += it.random_word % 32'd1000;
      if (snr < snr_cap) d += (snr_cap - snr) * 200;
      if (d < mrq_pkg::DELAY_MIN) d = mrq_pkg::DELAY_MIN;
      if (d > mrq_pkg::DELAY_MAX) d = mrq_pkg::DELAY_MAX;
      seen = 1'b0;
      for (p = head; p != tail; p = (p + 1) % DEPTH)
        if (slot_ctr[p] == it.msg_counter) seen = 1'b1;
      if (seen) begin
        r.status = mrq_pkg::ST_DUP;
      end else if ((tail + 1) % DEPTH == head) begin
        // full: oldest goes, the newcomer is not stored
        r.status = mrq_pkg::ST_FULL_EVICTED;
        head = (head + 1) % DEPTH;
      end else begin
        r.status = mrq_pkg::ST_QUEUED;
        slot_tag[tail] = it.msg_tag;
        slot_ctr[tail] = it.msg_counter;
        slot_delay[tail] = d[13:0];
        r.relay_delay_ms = d[13:0];
        tail = (tail + 1) % DEPTH;
      end
    end
    return r;
  endfunction

  function automatic mrq_pkg::in_item_t msg(input logic mode, input logic [15:0] tag,
                                            input logic [15:0] ctr, input logic [15:0] ttl,
                                            input logic [7:0] snr, input logic [15:0] toa,
                                            input logic [31:0] rnd);
    return {mode, tag, ctr, ttl, snr, toa, rnd};
  endfunction

  function automatic mrq_pkg::out_item_t result(input mrq_pkg::status_t st,
                                                input logic [13:0] d,
                                                input logic [15:0] tag,
                                                input logic [15:0] ctr);
    return {st, d, tag, ctr};
  endfunction

  function automatic stim_row_t beat_row(input mrq_pkg::in_item_t it, input int reps,
                                         input bit typed, input mrq_pkg::out_item_t want);
    stim_row_t row;
    row.kind = ROW_BEAT;
    row.idx = '0;
    row.val = '0;
    row.item = it;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [mrq_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [mrq_pkg::CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = beat_row('0, 0, 1'b0, '0);
    row.kind = ROW_REG;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  // mostly well-formed offers and pops; the rest is raw noise
  function automatic mrq_pkg::in_item_t make_beat(input int pop_pct);
    mrq_pkg::in_item_t it;
    logic [127:0] noise;
    int           roll;
    noise = {$urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(mrq_pkg::in_item_t)-1:0];
    roll = $urandom_range(99, 0);
    if (roll < pop_pct) begin
      it.mode = 1'b1;
    end else if (roll < 90) begin
      it.mode = 1'b0;
      it.msg_ttl = 16'($urandom_range(32767, 1));
      it.snr_db = 8'($urandom_range(snr_cap + 128, 0) - 128);
      if ($urandom_range(1, 0) != 0) it.msg_counter = 16'($urandom_range(CTR_POOL - 1, 0));
      if ($urandom_range(3, 0) != 0) it.toa_ms = 16'($urandom_range(4000, 0));
    end
    return it;
  endfunction

  task automatic send_beat(input mrq_pkg::in_item_t it, input bit typed,
                           input mrq_pkg::out_item_t want);
    mrq_pkg::out_item_t predicted;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predicted = admit_beat(it);
    awaited_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // only with nothing in flight
  task automatic write_reg(input logic [mrq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mrq_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mrq_pkg::REG_RELAY_ENABLE) relay_on = val[0];
    else snr_cap = $signed(val);
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected beat: status %0d delay %0d tag %h counter %h", $time,
                 out_data.status, out_data.relay_delay_ms, out_data.out_tag,
                 out_data.out_counter);
        mismatches++;
      end else begin
        oldest_result = awaited_results.pop_front();
        if (out_data.status !== oldest_result.status ||
            out_data.relay_delay_ms !== oldest_result.relay_delay_ms ||
            out_data.out_tag !== oldest_result.out_tag ||
            out_data.out_counter !== oldest_result.out_counter) begin
          $display("%0t: mismatch: expected status %0d delay %0d tag %h counter %h",
                   $time, oldest_result.status, oldest_result.relay_delay_ms,
                   oldest_result.out_tag, oldest_result.out_counter);
          $display("%0t:           actual   status %0d delay %0d tag %h counter %h",
                   $time, out_data.status, out_data.relay_delay_ms, out_data.out_tag,
                   out_data.out_counter);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("mesh_relay_admission_queue_test NOT OK");
    $finish;
  end

  initial begin
    stim_row_t         row;
    mrq_pkg::in_item_t it;
    int                k;
    int                ph;
    int                seg;
    int                pop_pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    plan.push_back(beat_row(msg(1'b1, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 32'h0), 1, 1'b1,
                            result(mrq_pkg::ST_EMPTY, 14'd0, 16'h0, 16'h0)));
    plan.push_back(beat_row(msg(1'b0, 16'hFFFF, 16'hFFFF, 16'h7FFF, 8'h7F, 16'hFFFF,
                                32'hFFFFFFFF), 1, 1'b1,
                            result(mrq_pkg::ST_DISABLED, 14'd0, 16'h0, 16'h0)));
    plan.push_back(reg_row(mrq_pkg::REG_RELAY_ENABLE, 8'h01));
    plan.push_back(reg_row(mrq_pkg::REG_SNR_LIMIT, 8'h80));
    plan.push_back(beat_row(msg(1'b0, 16'h0011, 16'h0011, 16'h0001, 8'h7F, 16'h0, 32'h0), 1,
                            1'b1, result(mrq_pkg::ST_SNR_HIGH, 14'd0, 16'h0, 16'h0)));
    plan.push_back(beat_row(msg(1'b0, 16'h0012, 16'h0012, 16'h0000, 8'h80, 16'h0, 32'h0), 1,
                            1'b1, result(mrq_pkg::ST_TTL_EXPIRED, 14'd0, 16'h0, 16'h0)));
    plan.push_back(beat_row(msg(1'b0, 16'h0013, 16'h0013, 16'h8000, 8'h80, 16'h0, 32'h0), 1,
                            1'b1, result(mrq_pkg::ST_TTL_EXPIRED, 14'd0, 16'h0, 16'h0)));
    // snr at the limit, delay clamped up
    plan.push_back(beat_row(msg(1'b0, 16'h1234, 16'h0001, 16'h0001, 8'h80, 16'h0, 32'h0), 1,
                            1'b1, result(mrq_pkg::ST_QUEUED, 14'd1000, 16'h0, 16'h0)));
    plan.push_back(beat_row(msg(1'b0, 16'h5678, 16'h0001, 16'h0005, 8'h80, 16'h0, 32'h0), 1,
                            1'b1, result(mrq_pkg::ST_DUP, 14'd0, 16'h0, 16'h0)));
    plan.push_back(beat_row(msg(1'b1, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 32'h0), 1, 1'b1,
                            result(mrq_pkg::ST_POPPED, 14'd1000, 16'h1234, 16'h0001)));
    plan.push_back(reg_row(mrq_pkg::REG_SNR_LIMIT, 8'h7F));
    plan.push_back(beat_row(msg(1'b0, 16'h0000, 16'h0002, 16'h7FFF, 8'h80, 16'hFFFF,
                                32'hFFFFFFFF), 1, 1'b1,
                            result(mrq_pkg::ST_QUEUED, 14'd10000, 16'h0, 16'h0)));
    plan.push_back(beat_row(msg(1'b0, 16'h0003, 16'h0003, 16'h0001, 8'h7F, 16'd500,
                                32'd1234), 1, 1'b0, '0));
    plan.push_back(beat_row(msg(1'b0, 16'h0004, 16'h0004, 16'h0002, 8'd100, 16'd2000,
                                32'd999999), 1, 1'b0, '0));
    plan.push_back(beat_row(msg(1'b0, 16'h4000, 16'd100, 16'd3, 8'd120, 16'd10, 32'd5), 12,
                            1'b0, '0));
    plan.push_back(beat_row(msg(1'b0, 16'h4444, 16'd200, 16'd1, 8'd0, 16'd0, 32'd0), 1, 1'b1,
                            result(mrq_pkg::ST_FULL_EVICTED, 14'd0, 16'h0, 16'h0)));
    plan.push_back(beat_row(msg(1'b1, 16'hABCD, 16'h0, 16'h0, 8'h0, 16'h0, 32'h0), 3, 1'b0,
                            '0));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.idx, row.val);
      end else begin
        for (k = 0; k < row.reps; k++) begin
          it = row.item;
          it.msg_counter = row.item.msg_counter + 16'(k);
          it.msg_tag = row.item.msg_tag + 16'(k);
          send_beat(it, row.typed, row.want);
        end
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 18 : 0;
      for (seg = 0; seg < SEGMENTS; seg++) begin
        write_reg(mrq_pkg::REG_RELAY_ENABLE, (ph == 1 && seg == 2) ? 8'h00 : 8'h01);
        unique case (seg)
          0:       write_reg(mrq_pkg::REG_SNR_LIMIT, 8'h80);
          1:       write_reg(mrq_pkg::REG_SNR_LIMIT, 8'h7F);
          default: write_reg(mrq_pkg::REG_SNR_LIMIT, 8'($urandom_range(255, 0)));
        endcase
        // long receiver hold-off so the block backs up into its input
        if (seg == 0 && ph != 1) hold_off_req = 1'b1;
        pop_pct = $urandom_range(55, 15);
        repeat (SEG_BEATS) send_beat(make_beat(pop_pct), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("mesh_relay_admission_queue_test OK");
    end else begin
      $display("mesh_relay_admission_queue_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: mesh_relay_admission_queue.f
+incdir+design
design/mrq_pkg.sv
design/mrq_ram.sv
design/mrq_front.sv
design/mrq_cmdq.sv
design/mrq_back.sv
design/mesh_relay_admission_queue.sv
bench/mesh_relay_admission_queue_test.sv
